[rtl/signed_int_to_decimal_ascii_assert.svh]
// assertion macros shared by the rtl modules
// every use expects clk_i and rst_ni in the enclosing module
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property checked on every clock edge outside reset
`define SIDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// condition on one edge implies a consequence on the next edge
`define SIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SIDA_ASSERT(lbl, prop, msg)
`define SIDA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/sida_pkg.sv]
package sida_pkg;

  // ascii output
  localparam int unsigned CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  // bcd digits and double dabble
  localparam int unsigned BCD_W = 4;
  localparam int unsigned BITS_PER_STEP = 4;
  localparam logic [BCD_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [BCD_W-1:0] DABBLE_ADD   = 4'd3;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

endpackage

[rtl/sida_front.sv]
module sida_front import sida_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic                          push_neg_o,
  output logic [VALUE_WIDTH-1:0]        push_mag_o
);

  logic [VALUE_WIDTH-1:0] raw;

  // split into sign and unsigned magnitude, the most negative value stays exact
  assign raw          = $unsigned(value_i);
  assign push_neg_o   = raw[VALUE_WIDTH-1];
  assign push_mag_o   = push_neg_o ? VALUE_WIDTH'(~raw + 1'b1) : raw;
  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

[rtl/sida_fifo.sv]
`include "signed_int_to_decimal_ascii_assert.svh"

module sida_fifo import sida_pkg::*; #(
  parameter int unsigned WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0]       mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;
  logic                   push, pop;

  assign push_ready_o = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  `SIDA_ASSERT(a_fifo_level, count_q <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue level above depth")
  `SIDA_ASSERT_NEXT(a_fifo_fill, push && !pop && (count_q == '0), pop_valid_o, "queue lost entry")

endmodule

[rtl/sida_conv.sv]
`include "signed_int_to_decimal_ascii_assert.svh"

module sida_conv import sida_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned NUM_DIGITS  = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_neg_i,
  input  logic [VALUE_WIDTH-1:0]        in_mag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_neg_o,
  output logic [NUM_DIGITS*BCD_W-1:0]   out_digits_o
);

  localparam int unsigned STEPS     = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned PAD_W     = STEPS * BITS_PER_STEP;
  localparam int unsigned BCD_TOTAL = NUM_DIGITS * BCD_W;
  localparam int unsigned CNT_W     = $clog2(STEPS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } conv_state_e;

  conv_state_e          state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [PAD_W-1:0]     shift_q, step_sh;
  logic [BCD_TOTAL-1:0] bcd_q, step_bcd;
  logic                 neg_q;
  logic                 load;

  assign in_ready_o   = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_ready_i);
  assign load         = in_valid_i && in_ready_o;
  assign out_valid_o  = (state_q == ST_DONE);
  assign out_neg_o    = neg_q;
  assign out_digits_o = bcd_q;

  // several shift-add-3 rounds per cycle, digits adjusted side by side
  always_comb begin
    step_bcd = bcd_q;
    step_sh  = shift_q;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (step_bcd[d*BCD_W +: BCD_W] >= DABBLE_LIMIT) begin
          step_bcd[d*BCD_W +: BCD_W] = step_bcd[d*BCD_W +: BCD_W] + DABBLE_ADD;
        end
      end
      step_bcd = {step_bcd[BCD_TOTAL-2:0], step_sh[PAD_W-1]};
      step_sh  = {step_sh[PAD_W-2:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = ST_RUN;
          cnt_d   = CNT_W'(STEPS);
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_RUN;
          cnt_d   = CNT_W'(STEPS);
        end else if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      shift_q <= PAD_W'(in_mag_i);
      bcd_q   <= '0;
      neg_q   <= in_neg_i;
    end else if (state_q == ST_RUN) begin
      shift_q <= step_sh;
      bcd_q   <= step_bcd;
    end
  end

  `SIDA_ASSERT(a_run_count, (state_q == ST_RUN) |-> (cnt_q != '0), "conversion count ran out")
  `SIDA_ASSERT_NEXT(a_done_hold, (state_q == ST_DONE) && !out_ready_i, state_q == ST_DONE, "result dropped")

endmodule

[rtl/sida_emit.sv]
`include "signed_int_to_decimal_ascii_assert.svh"

module sida_emit import sida_pkg::*; #(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_neg_i,
  input  logic [NUM_DIGITS*BCD_W-1:0] in_digits_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [CHAR_W-1:0]           char_code_o,
  output logic                        last_char_o
);

  localparam int unsigned IDX_W = $clog2(NUM_DIGITS);

  logic [BCD_W-1:0]  dig_q [NUM_DIGITS];
  logic [IDX_W-1:0]  idx_q, top_idx;
  logic              active_q, sign_pend_q, out_valid_q;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic [BCD_W-1:0]  cur_digit;
  logic              load, adv, emit_now;

  assign in_ready_o  = !active_q;
  assign load        = in_valid_i && in_ready_o;
  assign adv         = !out_valid_q || out_ready_i;
  assign emit_now    = active_q && adv;
  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  // highest nonzero digit, zero itself leaves a single digit
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (in_digits_i[i*BCD_W +: BCD_W] != '0) top_idx = IDX_W'(i);
    end
  end

  assign cur_digit = dig_q[idx_q];
  assign char_d    = sign_pend_q ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(cur_digit));
  assign last_d    = !sign_pend_q && (idx_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      sign_pend_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        active_q    <= 1'b1;
        sign_pend_q <= in_neg_i;
        idx_q       <= top_idx;
      end else if (emit_now) begin
        if (sign_pend_q) begin
          sign_pend_q <= 1'b0;
        end else if (idx_q == '0) begin
          active_q <= 1'b0;
        end else begin
          idx_q <= idx_q - 1'b1;
        end
      end
      if (emit_now) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        dig_q[i] <= in_digits_i[i*BCD_W +: BCD_W];
      end
    end
    if (emit_now) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

  `SIDA_ASSERT(a_minus_not_last, out_valid_q && (char_q == CHAR_MINUS) |-> !last_q, "sign marked last")
  `SIDA_ASSERT(a_idle_no_sign, in_ready_o |-> !sign_pend_q, "sign pending while idle")

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o  | value_i
// out     | output    | out_valid_o / out_ready_i | char_code_o, last_char_o
//
// a request passes the front in the cycle it is taken and waits in a two-entry queue
// the converter runs ceil(VALUE_WIDTH/4) steps of four bits, 8 at the default width,
// then holds the finished digits until the emitter takes them
// the emitter sends one character per cycle unless the output stalls, minus sign first
// for a negative value, then reloads from the converter before the next request
// reset clears all control state, no clearing pass is needed
// a stalled output freezes the emitter while the converter and queue keep filling
module signed_int_to_decimal_ascii import sida_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [CHAR_W-1:0]             char_code_o,
  output logic                          last_char_o
);

  // enough decimal digits for the largest magnitude, 1233/4096 approximates log10(2)
  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int unsigned Q_WIDTH    = VALUE_WIDTH + 1;

  // front to queue
  logic                         push_valid, push_ready, push_neg;
  logic [VALUE_WIDTH-1:0]       push_mag;
  // queue to converter
  logic                         pop_valid, pop_ready;
  logic [Q_WIDTH-1:0]           pop_data;
  // converter to emitter
  logic                         conv_valid, conv_ready, conv_neg;
  logic [NUM_DIGITS*BCD_W-1:0]  conv_digits;

  // sign and magnitude split
  sida_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_neg_o  (push_neg),
    .push_mag_o  (push_mag)
  );

  // short queue decoupling front and back
  sida_fifo #(
    .WIDTH(Q_WIDTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({push_neg, push_mag}),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  // binary magnitude to bcd, four bits per cycle
  sida_conv #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pop_valid),
    .in_ready_o  (pop_ready),
    .in_neg_i    (pop_data[Q_WIDTH-1]),
    .in_mag_i    (pop_data[VALUE_WIDTH-1:0]),
    .out_valid_o (conv_valid),
    .out_ready_i (conv_ready),
    .out_neg_o   (conv_neg),
    .out_digits_o(conv_digits)
  );

  // character sequencer with registered output
  sida_emit #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (conv_valid),
    .in_ready_o (conv_ready),
    .in_neg_i   (conv_neg),
    .in_digits_i(conv_digits),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .last_char_o(last_char_o)
  );

endmodule
